// ===== hdl/tlc_pkg.sv =====
// ---------------------------------------------------------------------------
// tlc_pkg: shared types and recognizer tables
// Character codes, recognizer state codes, class codes and the step and
// verdict functions of the integer, decimal and dotted-date recognizers.
// ---------------------------------------------------------------------------
package tlc_pkg;

    // Character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Integer recognizer states
    localparam logic [1:0] INT_START = 2'd0;
    localparam logic [1:0] INT_DIGS  = 2'd1;
    localparam logic [1:0] INT_DEAD  = 2'd3;

    // Decimal recognizer states
    localparam logic [2:0] DEC_START = 3'd0;
    localparam logic [2:0] DEC_IDIG  = 3'd1;
    localparam logic [2:0] DEC_DOT   = 3'd2;
    localparam logic [2:0] DEC_FDIG  = 3'd3;
    localparam logic [2:0] DEC_EXP   = 3'd4;
    localparam logic [2:0] DEC_ESGN  = 3'd5;
    localparam logic [2:0] DEC_EDIG  = 3'd6;
    localparam logic [2:0] DEC_DEAD  = 3'd7;

    // Dotted-date recognizer: even = expecting a group digit, odd = in a group
    localparam logic [3:0] DOT_START = 4'd0;
    localparam logic [3:0] DOT_G3    = 4'd5;
    localparam logic [3:0] DOT_G4    = 4'd7;
    localparam logic [3:0] DOT_LAST  = 4'd9;
    localparam logic [3:0] DOT_DEAD  = 4'd15;

    // Token classes
    typedef enum logic [2:0] {
        CLS_INT  = 3'd0,
        CLS_DEC  = 3'd1,
        CLS_DATE = 3'd2,
        CLS_HOUR = 3'd3,
        CLS_MIN  = 3'd4,
        CLS_STR  = 3'd5
    } t_class;

    typedef struct packed {
        logic [1:0] int_st;
        logic [2:0] dec_st;
        logic [3:0] dot_st;
    } t_bank;

    localparam t_bank BANK_START = '{int_st: INT_START, dec_st: DEC_START,
                                     dot_st: DOT_START};

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic logic [1:0] step_int(input logic [1:0] s, input logic [7:0] c);
        logic [1:0] r;
        r = INT_DEAD;
        if (s == INT_START) begin
            if (is_sign(c)) r = INT_START;
            else if (is_digit(c)) r = INT_DIGS;
        end else if (s == INT_DIGS && is_digit(c)) begin
            r = INT_DIGS;
        end
        return r;
    endfunction

    function automatic logic [2:0] step_dec(input logic [2:0] s, input logic [7:0] c);
        logic       d;
        logic [2:0] r;
        d = is_digit(c);
        r = DEC_DEAD;
        unique case (s)
            DEC_START: r = is_sign(c) ? DEC_START : (d ? DEC_IDIG : DEC_DEAD);
            DEC_IDIG:  r = d ? DEC_IDIG : ((c == CH_DOT) ? DEC_DOT : DEC_DEAD);
            DEC_DOT:   r = d ? DEC_FDIG : DEC_DEAD;
            DEC_FDIG:  r = d ? DEC_FDIG :
                           ((c == CH_LE || c == CH_UE) ? DEC_EXP : DEC_DEAD);
            DEC_EXP:   r = is_sign(c) ? DEC_ESGN : (d ? DEC_EDIG : DEC_DEAD);
            DEC_ESGN:  r = d ? DEC_EDIG : DEC_DEAD;
            DEC_EDIG:  r = d ? DEC_EDIG : DEC_DEAD;
            default:   r = DEC_DEAD;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] step_dot(input logic [3:0] s, input logic [7:0] c);
        logic [3:0] r;
        r = DOT_DEAD;
        if (s <= DOT_LAST) begin
            if (!s[0]) begin
                if (is_digit(c)) r = s + 4'd1;
            end else if (is_digit(c)) begin
                r = s;
            end else if (c == CH_DOT && s < DOT_LAST) begin
                r = s + 4'd1;
            end
        end
        return r;
    endfunction

    function automatic t_bank step_bank(input t_bank b, input logic [7:0] c);
        t_bank r;
        r.int_st = step_int(b.int_st, c);
        r.dec_st = step_dec(b.dec_st, c);
        r.dot_st = step_dot(b.dot_st, c);
        return r;
    endfunction

    // First match wins
    function automatic t_class bank_class(input t_bank b);
        t_class r;
        priority if (b.int_st == INT_DIGS)                         r = CLS_INT;
        else if (b.dec_st == DEC_FDIG || b.dec_st == DEC_EDIG)     r = CLS_DEC;
        else if (b.dot_st == DOT_LAST)                             r = CLS_MIN;
        else if (b.dot_st == DOT_G4)                               r = CLS_HOUR;
        else if (b.dot_st == DOT_G3)                               r = CLS_DATE;
        else                                                       r = CLS_STR;
        return r;
    endfunction

endpackage

// ===== hdl/tlc_if.sv =====
// ---------------------------------------------------------------------------
// tlc_if: valid/ready channels of the classifier
// Byte channel into the block and class channel out of it.
// ---------------------------------------------------------------------------
interface tlc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface tlc_class_if;
    logic       valid;
    logic       ready;
    logic [2:0] token_class;

    modport source (output valid, output token_class, input ready);
    modport sink   (input valid, input token_class, output ready);
endinterface

// ===== hdl/tlc_bank.sv =====
// ---------------------------------------------------------------------------
// tlc_bank: one bank of literal recognizers
// Integer, decimal and dotted-date recognizers stepped side by side; gives
// the verdict of the state after the current step.
// ---------------------------------------------------------------------------
module tlc_bank (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_clear,
    input  logic [7:0]          i_char,
    output tlc_pkg::t_class     o_class
);

    tlc_pkg::t_bank r_state;
    tlc_pkg::t_bank n_state;

    // Next state and its verdict
    always_comb begin
        n_state = i_step ? tlc_pkg::step_bank(r_state, i_char) : r_state;
        o_class = tlc_pkg::bank_class(n_state);
    end

    // State register; cleared at the end of a token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state <= tlc_pkg::BANK_START;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/token_literal_classifier_core.sv =====
// ---------------------------------------------------------------------------
// token_literal_classifier_core: numeric literal classifier
// Classifies a byte-serial token as integer, decimal, date, date-hour,
// date-minute or string.
// ---------------------------------------------------------------------------
// Takes one byte per cycle, except while a final byte waits for room in the
// output register, with last_char marking the final byte of each token; one
// class item comes out per token. A byte is registered in the input register,
// where the first recognizer bank steps on it and, from the third byte on,
// the second bank steps on the byte held before it; the class of a token
// lands in the output register as its final byte leaves the input register.
// The output register stalls only final bytes; other bytes keep flowing while
// a result waits. A quoted token of three or more bytes is classified on its
// inner bytes, which the second bank sees with one byte of delay.
module token_literal_classifier_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tlc_byte_if.sink       i_byte,
    tlc_class_if.source    o_class
);

    // Input register
    logic        r_in_vld;
    logic [7:0]  r_in_char;
    logic        r_in_last;

    // Token context
    logic [7:0]  r_held;
    logic        r_first_quote;
    logic [1:0]  r_count;

    // Output register
    logic            r_out_vld;
    tlc_pkg::t_class r_out_class;

    logic            adv;
    logic            strip_step;
    logic            use_strip;
    tlc_pkg::t_class plain_class;
    tlc_pkg::t_class strip_class;

    // Handshake: a final byte waits for room in the output register
    assign adv          = r_in_vld && (!r_in_last || !r_out_vld || o_class.ready);
    assign i_byte.ready = !r_in_vld || adv;

    assign strip_step = r_count[1];
    assign use_strip  = r_count[1] && r_first_quote && (r_in_char == tlc_pkg::CH_QUOTE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_vld <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_char <= i_byte.char_code;
            r_in_last <= i_byte.last_char;
        end
    end

    // Recognizer banks: every byte, and inner bytes only
    tlc_bank u_plain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_clear (adv && r_in_last),
        .i_char  (r_in_char),
        .o_class (plain_class)
    );

    tlc_bank u_strip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv && strip_step),
        .i_clear (adv && r_in_last),
        .i_char  (r_held),
        .o_class (strip_class)
    );

    // Held byte, first-quote flag and saturating byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held        <= 8'd0;
            r_first_quote <= 1'b0;
            r_count       <= 2'd0;
        end else if (adv) begin
            if (r_in_last) begin
                r_held        <= 8'd0;
                r_first_quote <= 1'b0;
                r_count       <= 2'd0;
            end else begin
                r_held <= r_in_char;
                if (r_count == 2'd0) r_first_quote <= (r_in_char == tlc_pkg::CH_QUOTE);
                if (r_count != 2'd3) r_count <= r_count + 2'd1;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (o_class.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out_class <= use_strip ? strip_class : plain_class;
        end
    end

    assign o_class.valid       = r_out_vld;
    assign o_class.token_class = r_out_class;

    // Checks
    a_final_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_last |=> r_out_vld)
        else $error("final byte did not produce a result");

    a_final_resets_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_last |=> (r_count == 2'd0) && !r_first_quote)
        else $error("token context not cleared after final byte");

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !r_in_last && (r_count != 2'd3) |=> r_count == $past(r_count) + 2'd1)
        else $error("byte count did not advance");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_class.ready |-> !(adv && r_in_last))
        else $error("pending result overwritten");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_out_class <= tlc_pkg::CLS_STR)
        else $error("class code out of range");

endmodule
